/* rtl/dapi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dapi_pkg: shared types and helpers for the d-axis pi current controller
// Holds the input and result words, the register file view, the multiplier
// handshake structs, state and operation codes, and saturation helpers.
// ----------------------------------------------------------------------------
package dapi_pkg;

	// register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_PROP_GAIN = 3'd0,
		REG_INTEGRAL_GAIN = 3'd1,
		REG_SAMPLE_TIME = 3'd2,
		REG_ACTIVE_RESISTANCE = 3'd3,
		REG_LEAKAGE_INDUCTANCE = 3'd4,
		REG_VOLTAGE_UPPER_LIMIT = 3'd5,
		REG_VOLTAGE_LOWER_LIMIT = 3'd6
	} reg_idx_t;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned NUM_DIGITS = DATA_W / DIGIT_W;
	localparam int unsigned DCNT_W = $clog2(NUM_DIGITS);

	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// input word
	typedef struct packed {
		logic signed [31:0] current_reference;
		logic signed [31:0] current_d_measured;
		logic signed [31:0] current_q_measured;
		logic signed [31:0] electrical_speed;
	} in_word_t;

	// result word
	typedef struct packed {
		logic signed [31:0] voltage_reference;
		logic clamped;
	} out_word_t;

	// register file contents
	typedef struct packed {
		logic signed [31:0] prop_gain;
		logic signed [31:0] integral_gain;
		logic [30:0] sample_time;
		logic signed [31:0] active_resistance;
		logic signed [31:0] leakage_inductance;
		logic signed [31:0] voltage_upper_limit;
		logic signed [31:0] voltage_lower_limit;
	} cfg_t;

	// multiplier request and result
	typedef struct packed {
		logic start;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} mul_req_t;

	typedef struct packed {
		logic done;
		logic busy;
		logic signed [31:0] q;
	} mul_res_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_MUL,
		ST_FIN
	} state_t;

	// product order within one sample
	typedef enum logic [2:0] {
		OP_TS_ERR,
		OP_LW,
		OP_KP_ERR,
		OP_KI_INT,
		OP_RA_ID,
		OP_WL_IQ
	} op_t;

	// saturate a 33-bit signed value to 32 bits
	function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
		logic signed [31:0] r;
		if (x[32] != x[31]) begin
			r = x[32] ? S32_MIN : S32_MAX;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	// saturate a 35-bit signed value to 32 bits
	function automatic logic signed [31:0] sat35(input logic signed [34:0] x);
		logic signed [31:0] r;
		if (x[34:31] != 4'b0000 && x[34:31] != 4'b1111) begin
			r = x[34] ? S32_MIN : S32_MAX;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

/* rtl/dapi_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dapi_cfg: configuration register file
// Seven gain, timing, resistance, inductance and limit registers written through a plain write port;
// writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module dapi_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [dapi_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input logic [31:0] cfg_wdata,
	output dapi_pkg::cfg_t cfg
);

	dapi_pkg::cfg_t regs_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				dapi_pkg::REG_PROP_GAIN: regs_q.prop_gain <= cfg_wdata;
				dapi_pkg::REG_INTEGRAL_GAIN: regs_q.integral_gain <= cfg_wdata;
				dapi_pkg::REG_SAMPLE_TIME: regs_q.sample_time <= cfg_wdata[30:0];
				dapi_pkg::REG_ACTIVE_RESISTANCE: regs_q.active_resistance <= cfg_wdata;
				dapi_pkg::REG_LEAKAGE_INDUCTANCE: regs_q.leakage_inductance <= cfg_wdata;
				dapi_pkg::REG_VOLTAGE_UPPER_LIMIT: regs_q.voltage_upper_limit <= cfg_wdata;
				dapi_pkg::REG_VOLTAGE_LOWER_LIMIT: regs_q.voltage_lower_limit <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = regs_q;

endmodule

/* rtl/dapi_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dapi_mul: digit-serial q16.16 multiplier
// Multiplies two signed 32-bit operands four multiplier bits per cycle,
// then floors the product by 16 bits and saturates it to 32 bits.
// ----------------------------------------------------------------------------
module dapi_mul (
	input logic clk,
	input logic arst_n,
	input dapi_pkg::mul_req_t req,
	output dapi_pkg::mul_res_t res
);

	logic signed [31:0] a_q;
	logic [31:0] b_q;
	logic signed [32:0] hi_q;
	logic [31:0] lo_q;
	logic [dapi_pkg::DCNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic last_digit;
	logic signed [dapi_pkg::DIGIT_W:0] digit;
	logic signed [36:0] pp;
	logic signed [36:0] sum;
	logic in_range;

	// one digit step: the top digit carries the sign of the multiplier
	always_comb begin
		last_digit = (cnt_q == dapi_pkg::DCNT_W'(dapi_pkg::NUM_DIGITS - 1));
		digit = last_digit ? {b_q[dapi_pkg::DIGIT_W-1], b_q[dapi_pkg::DIGIT_W-1:0]}
			: {1'b0, b_q[dapi_pkg::DIGIT_W-1:0]};
		pp = 37'(a_q) * 37'(digit);
		sum = 37'(hi_q) + pp;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_digit) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			hi_q <= '0;
		end else if (busy_q) begin
			b_q <= b_q >> dapi_pkg::DIGIT_W;
			hi_q <= sum[36:dapi_pkg::DIGIT_W];
			lo_q <= {sum[dapi_pkg::DIGIT_W-1:0], lo_q[31:dapi_pkg::DIGIT_W]};
		end
	end

	// floor by 16 and saturate
	always_comb begin
		in_range = (hi_q[31:15] == '0) || (hi_q[31:15] == '1);
		res.done = done_q;
		res.busy = busy_q;
		if (in_range) begin
			res.q = {hi_q[15:0], lo_q[31:16]};
		end else begin
			res.q = hi_q[32] ? dapi_pkg::S32_MIN : dapi_pkg::S32_MAX;
		end
	end

	// checks
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q && !done_q)
		else $error("multiplier started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done held longer than one cycle");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q))
		else $error("done without a running product");

endmodule

/* rtl/d_axis_pi_current_controller_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d_axis_pi_current_controller_top: d-axis pi current controller
// Pi controller with active resistance, cross-coupling cancellation,
// output clamp and reset-type anti-windup, in signed q16.16.
// ----------------------------------------------------------------------------
// Each sample word is finished before the next word can be accepted: the
// six products of the control law run one after another through a single
// digit-serial multiplier that handles four bits per cycle, followed by a
// finishing step for the sum, clamp and integral update. A finished result
// sits in an output register, so the next word is taken while it waits;
// the clamp step holds only if a second result is ready before the first
// one has been taken. Configuration registers reset to zero and are read
// while the products run, so a write during a sample can take effect on it.
// ----------------------------------------------------------------------------
module d_axis_pi_current_controller_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [dapi_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input logic [31:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input dapi_pkg::in_word_t in_data,
	output logic out_valid,
	input logic out_ready,
	output dapi_pkg::out_word_t out_data
);

	dapi_pkg::cfg_t cfg;
	dapi_pkg::mul_req_t mul_req;
	dapi_pkg::mul_res_t mul_res;

	dapi_pkg::state_t state_q, state_d;
	dapi_pkg::op_t op_q;

	logic signed [31:0] err_q;
	logic signed [31:0] id_q;
	logic signed [31:0] iq_q;
	logic signed [31:0] w_q;
	logic signed [31:0] wl_q;
	logic signed [31:0] integ_q;
	logic signed [31:0] acc_q;
	logic signed [34:0] sum_q;
	logic out_valid_q;
	dapi_pkg::out_word_t out_q;

	logic accept;
	logic fin_go;
	logic signed [31:0] err_d;
	logic signed [31:0] v;
	logic signed [31:0] o;
	logic limited;

	dapi_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.cfg(cfg)
	);

	dapi_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mul_req),
		.res(mul_res)
	);

	assign in_ready = (state_q == dapi_pkg::ST_IDLE);
	assign accept = in_valid && in_ready;
	assign fin_go = (state_q == dapi_pkg::ST_FIN) && (!out_valid_q || out_ready);
	assign err_d = dapi_pkg::sat33(33'(in_data.current_reference)
		- 33'(in_data.current_d_measured));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dapi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and multiplier start
	always_comb begin
		state_d = state_q;
		mul_req.start = 1'b0;
		unique case (state_q)
			dapi_pkg::ST_IDLE: begin
				if (in_valid) state_d = dapi_pkg::ST_START;
			end
			dapi_pkg::ST_START: begin
				mul_req.start = 1'b1;
				state_d = dapi_pkg::ST_MUL;
			end
			dapi_pkg::ST_MUL: begin
				if (mul_res.done) begin
					state_d = (op_q == dapi_pkg::OP_WL_IQ) ? dapi_pkg::ST_FIN
						: dapi_pkg::ST_START;
				end
			end
			dapi_pkg::ST_FIN: begin
				if (fin_go) state_d = dapi_pkg::ST_IDLE;
			end
			default: state_d = dapi_pkg::ST_IDLE;
		endcase
	end

	// operand selection for the current product
	always_comb begin
		case (op_q)
			dapi_pkg::OP_TS_ERR: begin
				mul_req.a = {1'b0, cfg.sample_time};
				mul_req.b = err_q;
			end
			dapi_pkg::OP_LW: begin
				mul_req.a = cfg.leakage_inductance;
				mul_req.b = w_q;
			end
			dapi_pkg::OP_KP_ERR: begin
				mul_req.a = cfg.prop_gain;
				mul_req.b = err_q;
			end
			dapi_pkg::OP_KI_INT: begin
				mul_req.a = cfg.integral_gain;
				mul_req.b = integ_q;
			end
			dapi_pkg::OP_RA_ID: begin
				mul_req.a = cfg.active_resistance;
				mul_req.b = id_q;
			end
			default: begin
				mul_req.a = wl_q;
				mul_req.b = iq_q;
			end
		endcase
	end

	// sum saturation and clamp, upper limit tested first
	always_comb begin
		v = dapi_pkg::sat35(sum_q);
		if (v >= cfg.voltage_upper_limit) begin
			o = cfg.voltage_upper_limit;
		end else if (v <= cfg.voltage_lower_limit) begin
			o = cfg.voltage_lower_limit;
		end else begin
			o = v;
		end
		limited = (o != v);
	end

	// control: product counter, stored integral, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= dapi_pkg::OP_TS_ERR;
			acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				op_q <= dapi_pkg::OP_TS_ERR;
			end else if (state_q == dapi_pkg::ST_MUL && mul_res.done
				&& op_q != dapi_pkg::OP_WL_IQ) begin
				op_q <= dapi_pkg::op_t'(op_q + 3'd1);
			end
			if (fin_go) begin
				acc_q <= limited ? '0 : integ_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// sample capture and product accumulation
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q <= err_d;
			id_q <= in_data.current_d_measured;
			iq_q <= in_data.current_q_measured;
			w_q <= in_data.electrical_speed;
			sum_q <= '0;
		end else if (state_q == dapi_pkg::ST_MUL && mul_res.done) begin
			case (op_q) inside
				dapi_pkg::OP_TS_ERR: integ_q <= dapi_pkg::sat33(33'(acc_q) + 33'(mul_res.q));
				dapi_pkg::OP_LW: wl_q <= mul_res.q;
				dapi_pkg::OP_KP_ERR, dapi_pkg::OP_KI_INT: sum_q <= sum_q + 35'(mul_res.q);
				default: sum_q <= sum_q - 35'(mul_res.q);
			endcase
		end
		if (fin_go) begin
			out_q.voltage_reference <= o;
			out_q.clamped <= limited;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// checks
	a_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_res.done |-> state_q == dapi_pkg::ST_MUL)
		else $error("product finished outside the multiply state");
	a_rise_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == dapi_pkg::ST_FIN))
		else $error("result appeared without a finishing step");
	a_windup_reset: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go && limited |=> acc_q == '0)
		else $error("integral kept after a clamped result");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_q))
		else $error("waiting result overwritten");

endmodule
